### hdl/depth_histogram_peak_window_macros.svh
// Assertion helpers, clocked on clk_i, held off while rst_ni is low
`ifndef DEPTH_HISTOGRAM_PEAK_WINDOW_MACROS_SVH
`define DEPTH_HISTOGRAM_PEAK_WINDOW_MACROS_SVH

`define DHPW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define DHPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dhpw_pkg.sv
package dhpw_pkg;

  localparam int HIST_BINS       = 256;
  localparam int BIN_W           = $clog2(HIST_BINS);
  localparam int COUNT_WIDTH_DEF = 21;
  localparam int COORD_WIDTH_DEF = 10;

  localparam int ROI_POS_W  = 10;
  localparam int ROI_LEN_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int START_W    = 9;

  localparam int SCAN_FIRST  = 15;
  localparam int SCAN_LAST   = 200;
  localparam int WINDOW_SPAN = 15;

  localparam logic [ROI_LEN_W-1:0] ROI_LEN_RST = ROI_LEN_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT = 2'd3;

  typedef struct packed {
    logic             pix_count;
    logic [BIN_W-1:0] pix_bin;
    logic             scan_start;
    logic             clear_start;
  } hist_cmd_t;

  typedef struct packed {
    logic clearing;
    logic scanning;
  } hist_stat_t;

endpackage

### hdl/dhpw_if.sv
interface dhpw_pix_if #(
  parameter int COORD_WIDTH = dhpw_pkg::COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             depth;
  logic [COORD_WIDTH-1:0] column;
  logic [COORD_WIDTH-1:0] row;
  logic                   last_pixel;

  modport source (output valid, depth, column, row, last_pixel, input ready);
  modport sink   (input valid, depth, column, row, last_pixel, output ready);
endinterface

interface dhpw_res_if;
  logic              valid;
  logic              ready;
  logic [7:0]        first_peak_bin;
  logic [7:0]        second_peak_bin;
  logic [7:0]        near_peak_bin;
  logic signed [8:0] window_lo;
  logic [7:0]        window_hi;

  modport source (output valid, first_peak_bin, second_peak_bin, near_peak_bin,
                  window_lo, window_hi, input ready);
  modport sink   (input valid, first_peak_bin, second_peak_bin, near_peak_bin,
                  window_lo, window_hi, output ready);
endinterface

interface dhpw_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dhpw_pkg::CFG_IDX_W-1:0]      index;
  logic [dhpw_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/depth_histogram_peak_window.sv
// Depth histogram peak window.
// in_i carries one pixel per transaction (depth, column, row, last_pixel);
// pixels inside the region of interest set over cfg_i are counted into a
// 256-bin histogram held in a single-port-read synchronous RAM.
// cfg_i writes the four region registers (left, top, width, height); it is
// always ready; the user is to write it only while the block is idle, as the
// block itself does not enforce this. Throughput: one pixel per cycle
// within a frame, set by the read-modify-write of the histogram RAM (one
// read and one write port). After a transaction with last_pixel set, in_i
// is not ready while the scan reads bins 14 to 201 one per cycle; the
// result is loaded into the out_o register once the scan is done and out_o
// is free. A clear sweep of all 256 RAM bins then follows, and likewise
// after reset, during which in_i is not ready; the next frame starts after it.
// out_o holds its result until taken; a stalled receiver only delays the
// loading of the next frame's result, pixels of that frame are still accepted.
module depth_histogram_peak_window #(
  parameter int COUNT_WIDTH = dhpw_pkg::COUNT_WIDTH_DEF,
  parameter int COORD_WIDTH = dhpw_pkg::COORD_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dhpw_pix_if.sink  in_i,
  dhpw_cfg_if.sink  cfg_i,
  dhpw_res_if.source out_o
);
  import dhpw_pkg::*;
  `include "depth_histogram_peak_window_macros.svh"

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             roi_hit, accept, out_free, out_load, peak_done;
  hist_cmd_t        hist_cmd;
  hist_stat_t       hist_stat;
  logic             scan_valid;
  logic [BIN_W-1:0] scan_bin;
  logic [COUNT_WIDTH-1:0] scan_data;
  logic [BIN_W-1:0] best_bin, runner_bin, near_bin;

  logic               out_valid_q, out_valid_d;
  logic [BIN_W-1:0]   first_q, second_q, near_q;
  logic [START_W-1:0] start_q;

  dhpw_roi #(.COORD_WIDTH(COORD_WIDTH)) u_roi (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .column_i (in_i.column),
    .row_i    (in_i.row),
    .inside_o (roi_hit)
  );

  dhpw_hist #(.COUNT_WIDTH(COUNT_WIDTH)) u_hist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (hist_cmd),
    .stat_o       (hist_stat),
    .scan_valid_o (scan_valid),
    .scan_bin_o   (scan_bin),
    .scan_data_o  (scan_data)
  );

  dhpw_peak #(.COUNT_WIDTH(COUNT_WIDTH)) u_peak (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (hist_cmd.scan_start),
    .scan_valid_i (scan_valid),
    .scan_bin_i   (scan_bin),
    .scan_data_i  (scan_data),
    .done_o       (peak_done),
    .best_bin_o   (best_bin),
    .runner_bin_o (runner_bin)
  );

  assign in_i.ready = (state_q == ST_RUN);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_FINISH) && out_free;
  assign near_bin   = (best_bin < runner_bin) ? best_bin : runner_bin;

  always_comb begin
    hist_cmd.pix_count   = accept && roi_hit;
    hist_cmd.pix_bin     = in_i.depth;
    hist_cmd.scan_start  = (state_q == ST_DRAIN);
    hist_cmd.clear_start = out_load;
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (!hist_stat.clearing) state_d = ST_RUN;
      ST_RUN:    if (accept && in_i.last_pixel) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_SCAN;
      ST_SCAN:   if (peak_done) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_CLEAR;
      default:   state_d = ST_CLEAR;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      first_q  <= best_bin;
      second_q <= runner_bin;
      near_q   <= near_bin;
      start_q  <= START_W'(near_bin) - START_W'(WINDOW_SPAN);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.first_peak_bin  = first_q;
  assign out_o.second_peak_bin = second_q;
  assign out_o.near_peak_bin   = near_q;
  assign out_o.window_lo       = $signed(start_q);
  assign out_o.window_hi       = near_q;

  `DHPW_ASSERT_IMPL(a_done_in_scan, peak_done, state_q == ST_SCAN, "peak done outside scan")
  `DHPW_ASSERT_IMPL(a_run_hist_idle, state_q == ST_RUN,
                    !hist_stat.clearing && !hist_stat.scanning, "pixels taken while busy")
  `DHPW_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_q, "loaded result not shown")

endmodule

### hdl/dhpw_roi.sv
module dhpw_roi #(
  parameter int COORD_WIDTH = dhpw_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dhpw_cfg_if.sink               cfg_i,
  input  logic [COORD_WIDTH-1:0] column_i,
  input  logic [COORD_WIDTH-1:0] row_i,
  output logic                   inside_o
);
  import dhpw_pkg::*;

  localparam int CmpW = (COORD_WIDTH > ROI_LEN_W + 1) ? COORD_WIDTH : ROI_LEN_W + 1;

  logic [ROI_POS_W-1:0] left_q, top_q;
  logic [ROI_LEN_W-1:0] width_q, height_q;
  logic [CmpW-1:0]      col_x, row_x, col_lo, col_hi, row_lo, row_hi;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= ROI_LEN_RST;
      height_q <= ROI_LEN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ROI_LEFT:   left_q   <= cfg_i.data[ROI_POS_W-1:0];
        REG_ROI_TOP:    top_q    <= cfg_i.data[ROI_POS_W-1:0];
        REG_ROI_WIDTH:  width_q  <= cfg_i.data[ROI_LEN_W-1:0];
        REG_ROI_HEIGHT: height_q <= cfg_i.data[ROI_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_x  = CmpW'(column_i);
    row_x  = CmpW'(row_i);
    col_lo = CmpW'(left_q);
    row_lo = CmpW'(top_q);
    col_hi = CmpW'(left_q) + CmpW'(width_q);
    row_hi = CmpW'(top_q) + CmpW'(height_q);
    inside_o = (col_x >= col_lo) && (col_x < col_hi) &&
               (row_x >= row_lo) && (row_x < row_hi);
  end

endmodule

### hdl/dhpw_hist.sv
module dhpw_hist #(
  parameter int COUNT_WIDTH = dhpw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dhpw_pkg::hist_cmd_t           cmd_i,
  output dhpw_pkg::hist_stat_t          stat_o,
  output logic                          scan_valid_o,
  output logic [dhpw_pkg::BIN_W-1:0]    scan_bin_o,
  output logic [COUNT_WIDTH-1:0]        scan_data_o
);
  import dhpw_pkg::*;
  `include "depth_histogram_peak_window_macros.svh"

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [BIN_W-1:0] ScanStartAddr = BIN_W'(SCAN_FIRST - 1);
  localparam logic [BIN_W-1:0] ScanStopAddr  = BIN_W'(SCAN_LAST + 1);
  localparam logic [BIN_W-1:0] LastAddr      = BIN_W'(HIST_BINS - 1);

  logic [COUNT_WIDTH-1:0] mem_q [HIST_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic [BIN_W-1:0]       rd_addr, rd_bin_q;
  logic                   rd_valid_q;

  logic                   clr_active_q;
  logic [BIN_W-1:0]       clr_cnt_q;
  logic                   scn_active_q;
  logic [BIN_W-1:0]       scn_addr_q;

  logic                   s1_valid_q;
  logic [BIN_W-1:0]       s1_bin_q;
  logic                   fwd_valid_q;
  logic [BIN_W-1:0]       fwd_bin_q;
  logic [COUNT_WIDTH-1:0] fwd_val_q;
  logic [COUNT_WIDTH-1:0] s1_old, s1_new;

  logic                   wr_en;
  logic [BIN_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  // back-to-back hits on one bin: the read raced the previous write
  always_comb begin
    s1_old  = (fwd_valid_q && (fwd_bin_q == s1_bin_q)) ? fwd_val_q : rd_data_q;
    s1_new  = (s1_old == CountMax) ? s1_old : s1_old + COUNT_WIDTH'(1);
    rd_addr = scn_active_q ? scn_addr_q : cmd_i.pix_bin;
    wr_en   = clr_active_q || s1_valid_q;
    wr_addr = clr_active_q ? clr_cnt_q : s1_bin_q;
    wr_data = clr_active_q ? '0 : s1_new;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      scn_active_q <= 1'b0;
      scn_addr_q   <= '0;
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      rd_valid_q   <= 1'b0;
    end else begin
      s1_valid_q  <= cmd_i.pix_count;
      fwd_valid_q <= s1_valid_q;
      rd_valid_q  <= scn_active_q;
      if (cmd_i.clear_start) begin
        clr_active_q <= 1'b1;
        clr_cnt_q    <= '0;
      end else if (clr_active_q) begin
        clr_cnt_q <= clr_cnt_q + BIN_W'(1);
        if (clr_cnt_q == LastAddr) begin
          clr_active_q <= 1'b0;
        end
      end
      if (cmd_i.scan_start) begin
        scn_active_q <= 1'b1;
        scn_addr_q   <= ScanStartAddr;
      end else if (scn_active_q) begin
        scn_addr_q <= scn_addr_q + BIN_W'(1);
        if (scn_addr_q == ScanStopAddr) begin
          scn_active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bin_q  <= cmd_i.pix_bin;
    fwd_bin_q <= s1_bin_q;
    fwd_val_q <= s1_new;
    rd_bin_q  <= rd_addr;
  end

  assign stat_o.clearing = clr_active_q;
  assign stat_o.scanning = scn_active_q || rd_valid_q;
  assign scan_valid_o    = rd_valid_q;
  assign scan_bin_o      = rd_bin_q;
  assign scan_data_o     = rd_data_q;

  `DHPW_ASSERT_IMPL(a_clr_no_pix_wr, clr_active_q, !s1_valid_q, "pixel write during clear")
  `DHPW_ASSERT_IMPL(a_clr_no_scan, clr_active_q, !scn_active_q, "scan overlaps clear")
  `DHPW_ASSERT_IMPL(a_scan_range, scn_active_q,
                    (scn_addr_q >= ScanStartAddr) && (scn_addr_q <= ScanStopAddr),
                    "scan address out of range")

endmodule

### hdl/dhpw_peak.sv
module dhpw_peak #(
  parameter int COUNT_WIDTH = dhpw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       scan_valid_i,
  input  logic [dhpw_pkg::BIN_W-1:0] scan_bin_i,
  input  logic [COUNT_WIDTH-1:0]     scan_data_i,
  output logic                       done_o,
  output logic [dhpw_pkg::BIN_W-1:0] best_bin_o,
  output logic [dhpw_pkg::BIN_W-1:0] runner_bin_o
);
  import dhpw_pkg::*;

  localparam int ScoreW = COUNT_WIDTH + 2;
  localparam logic [BIN_W-1:0] FirstScoreIn = BIN_W'(SCAN_FIRST + 1);
  localparam logic [BIN_W-1:0] LastBin      = BIN_W'(SCAN_LAST);

  logic [COUNT_WIDTH-1:0] w0_q, w1_q;
  logic                   sc_valid_q;
  logic [BIN_W-1:0]       sc_bin_q;
  logic [ScoreW-1:0]      sc_q;
  logic [BIN_W-1:0]       best_bin_q, run_bin_q;
  logic [ScoreW-1:0]      best_sc_q, run_sc_q;
  logic                   next_to_best;

  always_ff @(posedge clk_i) begin
    if (scan_valid_i) begin
      w1_q     <= w0_q;
      w0_q     <= scan_data_i;
      sc_q     <= ScoreW'(w1_q) + ScoreW'(w0_q) + ScoreW'(scan_data_i);
      sc_bin_q <= scan_bin_i - BIN_W'(1);
    end
  end

  assign next_to_best = (sc_bin_q - BIN_W'(1)) == best_bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
      best_bin_q <= '0;
      best_sc_q  <= '0;
      run_bin_q  <= '0;
      run_sc_q   <= '0;
    end else begin
      sc_valid_q <= scan_valid_i && (scan_bin_i >= FirstScoreIn);
      if (start_i) begin
        best_bin_q <= '0;
        best_sc_q  <= '0;
        run_bin_q  <= '0;
        run_sc_q   <= '0;
      end else if (sc_valid_q) begin
        if (sc_q >= best_sc_q) begin
          if (!next_to_best) begin
            run_bin_q <= best_bin_q;
            run_sc_q  <= best_sc_q;
          end
          best_bin_q <= sc_bin_q;
          best_sc_q  <= sc_q;
        end else if ((sc_q > run_sc_q) && !next_to_best) begin
          run_bin_q <= sc_bin_q;
          run_sc_q  <= sc_q;
        end
      end
    end
  end

  assign done_o       = sc_valid_q && (sc_bin_q == LastBin);
  assign best_bin_o   = best_bin_q;
  assign runner_bin_o = run_bin_q;

endmodule
